// ===== src/kickdown_switch_qualifier_unit_macros.svh =====
// assertion helpers for the kickdown switch qualifier
`ifndef KICKDOWN_SWITCH_QUALIFIER_UNIT_MACROS_SVH
`define KICKDOWN_SWITCH_QUALIFIER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled while in reset
`define KSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define KSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define KSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/ksq_pkg.sv =====
package ksq_pkg;

    localparam int CNT_W      = 16;
    localparam int CONF_W     = 8;
    localparam int POS_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_CONF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REHAB        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_LOW   = 3'd5;

    typedef enum logic [2:0] {
        ST_STBL_HI = 3'd0,
        ST_TR_HI   = 3'd1,
        ST_TR_INV  = 3'd2,
        ST_TR_LO   = 3'd3,
        ST_STBL_LO = 3'd4,
        ST_FLT_HI  = 3'd5,
        ST_FLT_INV = 3'd6,
        ST_FLT_LO  = 3'd7
    } ksq_state_t;

    typedef struct packed {
        logic [CONF_W-1:0] confirm_high_count;
        logic [CONF_W-1:0] confirm_low_count;
        logic [CONF_W-1:0] fault_confirm_count;
        logic [CONF_W-1:0] rehab_count;
        logic [POS_W-1:0]  pedal_threshold_high;
        logic [POS_W-1:0]  pedal_threshold_low;
    } ksq_cfg_t;

    typedef struct packed {
        logic valid_high;
        logic valid_low;
        logic push_inhibit;
    } ksq_sw_t;

    typedef struct packed {
        ksq_state_t state;
        logic       pressed;
    } ksq_fsm_out_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

// ===== src/kickdown_switch_qualifier_unit.sv =====
// kickdown switch qualifier
//
// s_axis carries one switch sample per beat: validity bits, push inhibit,
// pedal position and the coherence controls. m_axis returns one result beat
// per input beat, in order: qualified sensor state, pressed flag and the
// coherence fault. cfg writes one of six registers by index; indexes past the
// list are taken and dropped. cfg_ready is always high; writes are to be
// made only while no beat is in flight; the block does not enforce this.
//
// an input beat passes the input register, then the state update and result
// register. throughput: one beat per cycle while m_axis_tready drains the
// result register; the state machine update is a single pass of compares and
// a saturating 16-bit increment, so one beat can follow the next with no gap.
//
// reset: state machine in transient invalid, counters and pressed flag clear,
// registers at their defaults, both channels empty.
// stall: with m_axis_tready low the result register holds and the input
// register, if empty, still takes one more beat before s_axis_tready drops.
`include "kickdown_switch_qualifier_unit_macros.svh"

module kickdown_switch_qualifier_unit
    import ksq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [0] valid_high, [1] valid_low, [2] push_inhibit, [18:3] pedal_position,
    // [19] coherence_inhibit, [20] coherence_force, [23:21] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [2:0] sensor_state, [3] hard_point_pressed, [4] coherence_fault, [7:5] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ksq_cfg_t     cfg;
    ksq_fsm_out_t nxt;
    ksq_sw_t      sw;

    // input stage
    logic                 in_valid_reg;
    logic [IN_DATA_W-1:0] in_data_reg;

    // result stage
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic             step;
    logic [POS_W-1:0] pos;
    logic             coh_inh, coh_force, mismatch, coh_fault;

    // the result register frees up when empty or being drained this cycle
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    assign sw.valid_high   = in_data_reg[0];
    assign sw.valid_low    = in_data_reg[1];
    assign sw.push_inhibit = in_data_reg[2];
    assign pos             = in_data_reg[18:3];
    assign coh_inh         = in_data_reg[19];
    assign coh_force       = in_data_reg[20];

    ksq_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ksq_fsm u_fsm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .sw    (sw),
        .cfg   (cfg),
        .nxt   (nxt)
    );

    // coherence check uses the pressed flag after this beat's update
    assign mismatch  = (nxt.pressed && (pos < cfg.pedal_threshold_high)) ||
                       (!nxt.pressed && (pos > cfg.pedal_threshold_low));
    assign coh_fault = coh_force || (mismatch && !coh_inh);

    assign out_data_next = {3'b000, coh_fault, nxt.pressed, nxt.state};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // a processed beat always lands in the result register
    `KSQ_ASSERT_NEXT(a_step_out, clk, rst_n, step, out_valid_reg)
    // a waiting beat that cannot move stays in the input register
    `KSQ_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !step, in_valid_reg)
    // a stalled result is never overwritten
    `KSQ_ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_valid_reg && !m_axis_tready, !step)

endmodule

// ===== src/ksq_cfg_regs.sv =====
module ksq_cfg_regs
    import ksq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output ksq_cfg_t              cfg
);

    ksq_cfg_t cfg_reg;
    ksq_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CONFIRM_HIGH: cfg_next.confirm_high_count   = cfg_data[CONF_W-1:0];
                REG_CONFIRM_LOW:  cfg_next.confirm_low_count    = cfg_data[CONF_W-1:0];
                REG_FAULT_CONF:   cfg_next.fault_confirm_count  = cfg_data[CONF_W-1:0];
                REG_REHAB:        cfg_next.rehab_count          = cfg_data[CONF_W-1:0];
                REG_THRESH_HIGH:  cfg_next.pedal_threshold_high = cfg_data[POS_W-1:0];
                REG_THRESH_LOW:   cfg_next.pedal_threshold_low  = cfg_data[POS_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.confirm_high_count   <= 8'd3;
            cfg_reg.confirm_low_count    <= 8'd3;
            cfg_reg.fault_confirm_count  <= 8'd10;
            cfg_reg.rehab_count          <= 8'd5;
            cfg_reg.pedal_threshold_high <= 16'd0;
            cfg_reg.pedal_threshold_low  <= 16'hFFFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/ksq_fsm.sv =====
`include "kickdown_switch_qualifier_unit_macros.svh"

module ksq_fsm
    import ksq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  ksq_sw_t      sw,
    input  ksq_cfg_t     cfg,
    output ksq_fsm_out_t nxt
);

    ksq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] chg_cnt_reg, chg_cnt_next;
    logic [CNT_W-1:0] flt_cnt_reg, flt_cnt_next;
    logic             pressed_reg, pressed_next;

    logic [CNT_W-1:0] chg_inc, flt_inc;
    logic             flt_confirmed, hi_confirmed, lo_confirmed, rehab_done;
    logic             vh, vl;

    assign vh      = sw.valid_high;
    assign vl      = sw.valid_low;
    assign chg_inc = sat_inc(chg_cnt_reg);
    assign flt_inc = sat_inc(flt_cnt_reg);

    assign flt_confirmed = flt_cnt_reg >= {{(CNT_W-CONF_W){1'b0}}, cfg.fault_confirm_count};
    assign hi_confirmed  = chg_cnt_reg >= {{(CNT_W-CONF_W){1'b0}}, cfg.confirm_high_count};
    assign lo_confirmed  = chg_cnt_reg >= {{(CNT_W-CONF_W){1'b0}}, cfg.confirm_low_count};
    assign rehab_done    = chg_cnt_reg >= {{(CNT_W-CONF_W){1'b0}}, cfg.rehab_count};

    always_comb
    begin
        state_next   = state_reg;
        chg_cnt_next = chg_cnt_reg;
        flt_cnt_next = flt_cnt_reg;
        pressed_next = pressed_reg;

        unique case (state_reg)
            ST_STBL_HI:
            begin
                if (vl)
                begin
                    state_next   = ST_TR_LO;
                    chg_cnt_next = chg_inc;
                    flt_cnt_next = flt_inc;
                end
                else if (!vh)
                begin
                    state_next   = ST_TR_INV;
                    chg_cnt_next = '0;
                    flt_cnt_next = flt_inc;
                end
            end
            ST_TR_HI:
            begin
                if (flt_confirmed)
                begin
                    pressed_next = 1'b0;
                    flt_cnt_next = '0;
                    state_next   = vh ? ST_FLT_HI : (vl ? ST_FLT_LO : ST_FLT_INV);
                    chg_cnt_next = (vh || vl) ? CNT_W'(1) : '0;
                end
                else if (vl)
                begin
                    state_next   = ST_TR_LO;
                    chg_cnt_next = CNT_W'(1);
                    flt_cnt_next = flt_inc;
                end
                else if (!vh)
                begin
                    state_next   = ST_TR_INV;
                    chg_cnt_next = '0;
                    flt_cnt_next = flt_inc;
                end
                else if (hi_confirmed)
                begin
                    state_next   = ST_STBL_HI;
                    pressed_next = 1'b0;
                    chg_cnt_next = '0;
                    flt_cnt_next = '0;
                end
                else
                begin
                    chg_cnt_next = chg_inc;
                    flt_cnt_next = flt_inc;
                end
            end
            ST_TR_INV:
            begin
                if (flt_confirmed)
                begin
                    pressed_next = 1'b0;
                    flt_cnt_next = '0;
                    state_next   = vh ? ST_FLT_HI : (vl ? ST_FLT_LO : ST_FLT_INV);
                    chg_cnt_next = (vh || vl) ? CNT_W'(1) : '0;
                end
                else
                begin
                    flt_cnt_next = flt_inc;
                    if (vh)
                    begin
                        state_next   = ST_TR_HI;
                        chg_cnt_next = CNT_W'(1);
                    end
                    else if (vl)
                    begin
                        state_next   = ST_TR_LO;
                        chg_cnt_next = CNT_W'(1);
                    end
                    else
                    begin
                        chg_cnt_next = '0;
                    end
                end
            end
            ST_TR_LO:
            begin
                if (flt_confirmed)
                begin
                    pressed_next = 1'b0;
                    flt_cnt_next = '0;
                    state_next   = vh ? ST_FLT_HI : (vl ? ST_FLT_LO : ST_FLT_INV);
                    chg_cnt_next = (vh || vl) ? CNT_W'(1) : '0;
                end
                else if (vh)
                begin
                    state_next   = ST_TR_HI;
                    chg_cnt_next = CNT_W'(1);
                    flt_cnt_next = flt_inc;
                end
                else if (!vl)
                begin
                    state_next   = ST_TR_INV;
                    chg_cnt_next = '0;
                    flt_cnt_next = flt_inc;
                end
                else if (lo_confirmed && !sw.push_inhibit)
                begin
                    state_next   = ST_STBL_LO;
                    pressed_next = 1'b1;
                    chg_cnt_next = '0;
                    flt_cnt_next = '0;
                end
                else
                begin
                    chg_cnt_next = chg_inc;
                    flt_cnt_next = flt_inc;
                end
            end
            ST_STBL_LO:
            begin
                if (vh)
                begin
                    state_next   = ST_TR_HI;
                    chg_cnt_next = chg_inc;
                    flt_cnt_next = flt_inc;
                end
                else if (!vl)
                begin
                    state_next   = ST_TR_INV;
                    chg_cnt_next = '0;
                    flt_cnt_next = flt_inc;
                end
            end
            ST_FLT_HI:
            begin
                flt_cnt_next = '0;
                if (rehab_done && vh)
                begin
                    state_next   = ST_STBL_HI;
                    pressed_next = 1'b0;
                    chg_cnt_next = '0;
                end
                else if (vl)
                begin
                    state_next   = ST_FLT_LO;
                    pressed_next = 1'b0;
                    chg_cnt_next = CNT_W'(1);
                end
                else if (!vh)
                begin
                    state_next   = ST_FLT_INV;
                    pressed_next = 1'b0;
                    chg_cnt_next = '0;
                end
                else
                begin
                    chg_cnt_next = chg_inc;
                end
            end
            ST_FLT_INV:
            begin
                if (vh || vl)
                begin
                    state_next   = vh ? ST_FLT_HI : ST_FLT_LO;
                    pressed_next = 1'b0;
                    chg_cnt_next = chg_inc;
                    flt_cnt_next = '0;
                end
            end
            ST_FLT_LO:
            begin
                flt_cnt_next = '0;
                if (rehab_done && vl)
                begin
                    state_next   = ST_STBL_LO;
                    pressed_next = 1'b1;
                    chg_cnt_next = '0;
                end
                else if (vh)
                begin
                    state_next   = ST_FLT_HI;
                    pressed_next = 1'b0;
                    chg_cnt_next = CNT_W'(1);
                end
                else if (!vl)
                begin
                    state_next   = ST_FLT_INV;
                    pressed_next = 1'b0;
                    chg_cnt_next = '0;
                end
                else
                begin
                    chg_cnt_next = chg_inc;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    assign nxt.state   = state_next;
    assign nxt.pressed = pressed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_TR_INV;
            chg_cnt_reg <= '0;
            flt_cnt_reg <= '0;
            pressed_reg <= 1'b0;
        end
        else if (step)
        begin
            state_reg   <= state_next;
            chg_cnt_reg <= chg_cnt_next;
            flt_cnt_reg <= flt_cnt_next;
            pressed_reg <= pressed_next;
        end
    end

    // fault counter only runs in the transient states
    `KSQ_ASSERT_IMPL(a_flt_cnt_idle, clk, rst_n,
        state_reg == ST_STBL_HI || state_reg == ST_STBL_LO || state_reg == ST_FLT_HI ||
        state_reg == ST_FLT_INV || state_reg == ST_FLT_LO, flt_cnt_reg == '0)
    // pressed flag agrees with the stable and fault states
    `KSQ_ASSERT_IMPL(a_pressed_lo, clk, rst_n, state_reg == ST_STBL_LO, pressed_reg)
    `KSQ_ASSERT_IMPL(a_released, clk, rst_n,
        state_reg == ST_STBL_HI || state_reg == ST_FLT_HI || state_reg == ST_FLT_INV ||
        state_reg == ST_FLT_LO, !pressed_reg)
    // a clean high reading keeps stable high
    `KSQ_ASSERT_NEXT(a_hold_hi, clk, rst_n,
        step && state_reg == ST_STBL_HI && vh && !vl, state_reg == ST_STBL_HI)

endmodule

// ===== bench/tb_kickdown_switch_qualifier_unit.sv =====
module tb_kickdown_switch_qualifier_unit
    import ksq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // watchdog: cycles in a row with no beat on any channel
    localparam int STALL_LIMIT  = 2000;
    // cycles allowed after the last result before the end or a register write
    localparam int SETTLE_TICKS = 8;
    // long receiver hold-off, placed once the pipeline is busy
    localparam int HOLD_TICKS   = 90;
    localparam int HOLD_AFTER   = 150;

    // register indexes past the list, written to see them dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // switch readings used to build runs of samples
    typedef enum int {RD_HIGH, RD_LOW, RD_NONE, RD_BOTH} reading_t;

    // one expected result beat
    typedef struct packed {
        ksq_state_t st;
        logic       pressed;
        logic       coh_fault;
    } qualified_t;

    // tracks the qualifier state and the queue of qualified results still owed
    class kickdown_tracker;
        ksq_cfg_t         cfg;
        ksq_state_t       st;
        logic [CNT_W-1:0] change_cnt;
        logic [CNT_W-1:0] fault_cnt;
        logic             pressed;
        qualified_t       owed_q[$];
        int               mismatches;
        int               beat_no;

        function new();
            cfg.confirm_high_count   = 8'd3;
            cfg.confirm_low_count    = 8'd3;
            cfg.fault_confirm_count  = 8'd10;
            cfg.rehab_count          = 8'd5;
            cfg.pedal_threshold_high = 16'd0;
            cfg.pedal_threshold_low  = 16'hFFFF;
            st         = ST_TR_INV;
            change_cnt = '0;
            fault_cnt  = '0;
            pressed    = 1'b0;
            mismatches = 0;
            beat_no    = 0;
        endfunction

        // counters stick at all ones
        function logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
            if (&v)
                return v;
            return v + 1'b1;
        endfunction

        function void to_fault(input bit vh, input bit vl);
            pressed   = 1'b0;
            fault_cnt = '0;
            if (vh)
            begin
                st         = ST_FLT_HI;
                change_cnt = 16'd1;
            end
            else if (vl)
            begin
                st         = ST_FLT_LO;
                change_cnt = 16'd1;
            end
            else
            begin
                st         = ST_FLT_INV;
                change_cnt = '0;
            end
        endfunction

        function void step_machine(input bit vh, input bit vl, input bit inh);
            case (st)
                ST_STBL_HI:
                begin
                    if (vl)
                    begin
                        st         = ST_TR_LO;
                        change_cnt = bump(change_cnt);
                        fault_cnt  = bump(fault_cnt);
                    end
                    else if (!vh)
                    begin
                        st         = ST_TR_INV;
                        change_cnt = '0;
                        fault_cnt  = bump(fault_cnt);
                    end
                end
                ST_TR_HI:
                begin
                    if (fault_cnt >= cfg.fault_confirm_count)
                        to_fault(vh, vl);
                    else if (vl)
                    begin
                        st         = ST_TR_LO;
                        change_cnt = 16'd1;
                        fault_cnt  = bump(fault_cnt);
                    end
                    else if (!vh)
                    begin
                        st         = ST_TR_INV;
                        change_cnt = '0;
                        fault_cnt  = bump(fault_cnt);
                    end
                    else if (change_cnt >= cfg.confirm_high_count)
                    begin
                        st         = ST_STBL_HI;
                        pressed    = 1'b0;
                        change_cnt = '0;
                        fault_cnt  = '0;
                    end
                    else
                    begin
                        change_cnt = bump(change_cnt);
                        fault_cnt  = bump(fault_cnt);
                    end
                end
                ST_TR_INV:
                begin
                    if (fault_cnt >= cfg.fault_confirm_count)
                        to_fault(vh, vl);
                    else
                    begin
                        fault_cnt = bump(fault_cnt);
                        if (vh)
                        begin
                            st         = ST_TR_HI;
                            change_cnt = 16'd1;
                        end
                        else if (vl)
                        begin
                            st         = ST_TR_LO;
                            change_cnt = 16'd1;
                        end
                        else
                            change_cnt = '0;
                    end
                end
                ST_TR_LO:
                begin
                    if (fault_cnt >= cfg.fault_confirm_count)
                        to_fault(vh, vl);
                    else if (vh)
                    begin
                        st         = ST_TR_HI;
                        change_cnt = 16'd1;
                        fault_cnt  = bump(fault_cnt);
                    end
                    else if (!vl)
                    begin
                        st         = ST_TR_INV;
                        change_cnt = '0;
                        fault_cnt  = bump(fault_cnt);
                    end
                    else if (change_cnt >= cfg.confirm_low_count && !inh)
                    begin
                        st         = ST_STBL_LO;
                        pressed    = 1'b1;
                        change_cnt = '0;
                        fault_cnt  = '0;
                    end
                    else
                    begin
                        change_cnt = bump(change_cnt);
                        fault_cnt  = bump(fault_cnt);
                    end
                end
                ST_STBL_LO:
                begin
                    if (vh)
                    begin
                        st         = ST_TR_HI;
                        change_cnt = bump(change_cnt);
                        fault_cnt  = bump(fault_cnt);
                    end
                    else if (!vl)
                    begin
                        st         = ST_TR_INV;
                        change_cnt = '0;
                        fault_cnt  = bump(fault_cnt);
                    end
                end
                ST_FLT_HI:
                begin
                    fault_cnt = '0;
                    if (change_cnt >= cfg.rehab_count && vh)
                    begin
                        st         = ST_STBL_HI;
                        pressed    = 1'b0;
                        change_cnt = '0;
                    end
                    else if (vl)
                    begin
                        st         = ST_FLT_LO;
                        pressed    = 1'b0;
                        change_cnt = 16'd1;
                    end
                    else if (!vh)
                    begin
                        st         = ST_FLT_INV;
                        pressed    = 1'b0;
                        change_cnt = '0;
                    end
                    else
                        change_cnt = bump(change_cnt);
                end
                ST_FLT_INV:
                begin
                    if (vh)
                    begin
                        st         = ST_FLT_HI;
                        pressed    = 1'b0;
                        change_cnt = bump(change_cnt);
                        fault_cnt  = '0;
                    end
                    else if (vl)
                    begin
                        st         = ST_FLT_LO;
                        pressed    = 1'b0;
                        change_cnt = bump(change_cnt);
                        fault_cnt  = '0;
                    end
                end
                ST_FLT_LO:
                begin
                    fault_cnt = '0;
                    if (change_cnt >= cfg.rehab_count && vl)
                    begin
                        st         = ST_STBL_LO;
                        pressed    = 1'b1;
                        change_cnt = '0;
                    end
                    else if (vh)
                    begin
                        st         = ST_FLT_HI;
                        pressed    = 1'b0;
                        change_cnt = 16'd1;
                    end
                    else if (!vl)
                    begin
                        st         = ST_FLT_INV;
                        pressed    = 1'b0;
                        change_cnt = '0;
                    end
                    else
                        change_cnt = bump(change_cnt);
                end
                default:
                    st = ST_TR_INV;
            endcase
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_CONFIRM_HIGH: cfg.confirm_high_count   = d[CONF_W-1:0];
                REG_CONFIRM_LOW:  cfg.confirm_low_count    = d[CONF_W-1:0];
                REG_FAULT_CONF:   cfg.fault_confirm_count  = d[CONF_W-1:0];
                REG_REHAB:        cfg.rehab_count          = d[CONF_W-1:0];
                REG_THRESH_HIGH:  cfg.pedal_threshold_high = d[POS_W-1:0];
                REG_THRESH_LOW:   cfg.pedal_threshold_low  = d[POS_W-1:0];
                default:          ;
            endcase
        endfunction

        // one accepted switch sample: advance the machine, queue what comes out
        function void note_sample(input logic [IN_DATA_W-1:0] d);
            logic [POS_W-1:0] pos;
            logic             mismatch;
            qualified_t       q;
            pos = d[18:3];
            step_machine(d[0], d[1], d[2]);
            mismatch = (pressed && pos < cfg.pedal_threshold_high) ||
                       (!pressed && pos > cfg.pedal_threshold_low);
            q.st        = st;
            q.pressed   = pressed;
            q.coh_fault = d[20] || (mismatch && !d[19]);
            owed_q.push_back(q);
        endfunction

        task report(input string msg);
            mismatches++;
            $display("[%0t] result beat %0d: %s", $realtime, beat_no, msg);
        endtask

        task check_result(input logic [OUT_DATA_W-1:0] d);
            qualified_t q;
            if (owed_q.size() == 0)
                report("result beat with nothing owed");
            else
            begin
                q = owed_q.pop_front();
                if (d[2:0] !== q.st)
                    report($sformatf("sensor_state %0d, wanted %0d", d[2:0], q.st));
                if (d[3] !== q.pressed)
                    report($sformatf("hard_point_pressed %b, wanted %b", d[3], q.pressed));
                if (d[4] !== q.coh_fault)
                    report($sformatf("coherence_fault %b, wanted %b", d[4], q.coh_fault));
            end
            beat_no++;
        endtask

        function int owed();
            return owed_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [0] valid_high, [1] valid_low, [2] push_inhibit, [18:3] pedal_position,
    // [19] coherence_inhibit, [20] coherence_force, [23:21] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [2:0] sensor_state, [3] hard_point_pressed, [4] coherence_fault, [7:5] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kickdown_tracker tracker;
    int              results_seen;
    int              quiet_cycles;
    int              burst_left;
    bit              rx_holding;

    kickdown_switch_qualifier_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // sample every handshake at the rising edge; the tracker follows the same
    // beats the block takes, so register writes land in the same order too
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_sample(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                tracker.check_result(m_axis_tdata);
                results_seen++;
            end
        end
    end

    // watchdog: any beat on any channel counts as progress
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: stall pattern redrawn at random through the run, plus one long hold-off
    // once results are flowing so the block backs up into its input
    initial
    begin
        int  mode;
        int  cyc;
        bit  hold_done;
        m_axis_tready = 1'b0;
        mode          = 0;
        cyc           = 0;
        hold_done     = 1'b0;
        rx_holding    = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                rx_holding    = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_TICKS) @(negedge clk);
                rx_holding = 1'b0;
                hold_done  = 1'b1;
            end
            else
            begin
                if (cyc % 64 == 0)
                    mode = $urandom_range(0, 3);
                cyc++;
                case (mode)
                    0: m_axis_tready <= 1'b1;                         // no stalls
                    1: m_axis_tready <= 1'($urandom_range(0, 1));     // coin flip
                    2: m_axis_tready <= (cyc % 3 != 0);               // regular gaps
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0); // mostly stalled
                endcase
            end
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_sample(input bit vh, input bit vl,
                                                          input bit inh,
                                                          input logic [POS_W-1:0] pos,
                                                          input bit cinh, input bit cforce);
        return {3'b000, cforce, cinh, pos, inh, vl, vh};
    endfunction

    // one switch sample beat; bursts of random length with random gaps between,
    // no gaps while the receiver holds off so the input really backs up
    task automatic send_sample(input logic [IN_DATA_W-1:0] d);
        if (burst_left == 0)
        begin
            if (!rx_holding && $urandom_range(0, 3) != 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // stop offering beats and wait until every owed result has come back
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.owed() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic configure(input ksq_cfg_t c, input bit spare);
        write_cfg(REG_CONFIRM_HIGH, {8'd0, c.confirm_high_count});
        write_cfg(REG_CONFIRM_LOW,  {8'd0, c.confirm_low_count});
        write_cfg(REG_FAULT_CONF,   {8'd0, c.fault_confirm_count});
        write_cfg(REG_REHAB,        {8'd0, c.rehab_count});
        write_cfg(REG_THRESH_HIGH,  c.pedal_threshold_high);
        write_cfg(REG_THRESH_LOW,   c.pedal_threshold_low);
        // writes past the list must leave every register alone
        if (spare)
        begin
            write_cfg(REG_SPARE_6, 16'($urandom));
            write_cfg(REG_SPARE_7, 16'($urandom));
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // pedal position: extremes, values around either threshold, or anything
    function automatic logic [POS_W-1:0] pick_position();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return tracker.cfg.pedal_threshold_high + 16'($urandom_range(0, 2)) - 16'd1;
            3: return tracker.cfg.pedal_threshold_low + 16'($urandom_range(0, 2)) - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly steady runs of one reading (to confirm stable, fault and rehab
    // paths), with glitches inside runs and short bursts of pure noise
    task automatic run_random(input int n, input int maxrun);
        int       left;
        int       len;
        int       code;
        bit       inh_heavy;
        bit       vh;
        bit       vl;
        bit       inh;
        reading_t rd;
        left = n;
        while (left > 0)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                code      = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2) : 3;
                rd        = reading_t'(code);
                len       = $urandom_range(1, maxrun);
                inh_heavy = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < len && left > 0; i++)
                begin
                    vh = (rd == RD_HIGH) || (rd == RD_BOTH);
                    vl = (rd == RD_LOW) || (rd == RD_BOTH);
                    if ($urandom_range(0, 39) == 0)
                    begin
                        vh = 1'($urandom_range(0, 1));
                        vl = 1'($urandom_range(0, 1));
                    end
                    inh = inh_heavy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 19) == 0);
                    send_sample(pack_sample(vh, vl, inh, pick_position(),
                                            $urandom_range(0, 3) == 0,
                                            $urandom_range(0, 9) == 0));
                    left--;
                end
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len && left > 0; i++)
                begin
                    send_sample(pack_sample(1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)), 16'($urandom),
                                            1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1))));
                    left--;
                end
            end
        end
    endtask

    // one setting of the registers followed by a run of random samples
    task automatic run_phase(input ksq_cfg_t c, input int n, input int maxrun,
                             input bit spare);
        drain();
        configure(c, spare);
        run_random(n, maxrun);
    endtask

    initial
    begin
        ksq_cfg_t c;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        results_seen  = 0;
        quiet_cycles  = 0;
        burst_left    = 0;
        tracker       = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // short confirm times and mid thresholds so the directed walk is brief
        c.confirm_high_count   = 8'd2;
        c.confirm_low_count    = 8'd2;
        c.fault_confirm_count  = 8'd6;
        c.rehab_count          = 8'd2;
        c.pedal_threshold_high = 16'd40000;
        c.pedal_threshold_low  = 16'd20000;
        configure(c, 1'b1);

        // both bits from transient invalid: high wins
        send_sample(pack_sample(1, 1, 0, 16'd0, 0, 0));
        // both bits in transient high: low wins
        send_sample(pack_sample(1, 1, 0, 16'hFFFF, 0, 0));
        // push inhibit holds transient low past its confirm count
        send_sample(pack_sample(0, 1, 1, 16'hFFFF, 0, 0));
        send_sample(pack_sample(0, 1, 1, 16'hFFFF, 0, 0));
        // stable low, pressed with pedal at zero: mismatch, then inhibited
        send_sample(pack_sample(0, 1, 0, 16'd0, 0, 0));
        send_sample(pack_sample(0, 1, 0, 16'd0, 1, 0));
        // both bits in stable low: high wins, then confirm stable high
        send_sample(pack_sample(1, 1, 0, 16'd30000, 0, 0));
        send_sample(pack_sample(1, 0, 0, 16'd30000, 0, 0));
        send_sample(pack_sample(1, 0, 0, 16'hFFFF, 0, 0));
        // forced fault wins over inhibit
        send_sample(pack_sample(1, 0, 0, 16'hFFFF, 1, 1));
        // both bits in stable high: low wins
        send_sample(pack_sample(1, 1, 0, 16'd0, 0, 0));
        // invalid until the fault counter confirms, around the low threshold
        send_sample(pack_sample(0, 0, 0, 16'd20000, 0, 0));
        send_sample(pack_sample(0, 0, 0, 16'd20001, 0, 0));
        send_sample(pack_sample(0, 0, 0, 16'd19999, 0, 0));
        send_sample(pack_sample(0, 0, 0, 16'd20000, 0, 0));
        send_sample(pack_sample(0, 0, 0, 16'd20001, 0, 0));
        send_sample(pack_sample(0, 0, 0, 16'd0, 0, 0));
        // fault invalid, fault high, then both bits jump to fault low
        send_sample(pack_sample(1, 0, 0, 16'd0, 0, 0));
        send_sample(pack_sample(1, 1, 0, 16'd0, 0, 0));
        // rehab back to stable low, pedal around the high threshold
        send_sample(pack_sample(0, 1, 0, 16'd39999, 0, 0));
        send_sample(pack_sample(0, 1, 0, 16'd39999, 0, 0));
        send_sample(pack_sample(0, 1, 0, 16'd40000, 0, 0));
        send_sample(pack_sample(0, 0, 1, 16'hFFFF, 0, 1));

        // register defaults
        c.confirm_high_count   = 8'd3;
        c.confirm_low_count    = 8'd3;
        c.fault_confirm_count  = 8'd10;
        c.rehab_count          = 8'd5;
        c.pedal_threshold_high = 16'd0;
        c.pedal_threshold_low  = 16'hFFFF;
        run_phase(c, 100, 15, 1'b0);

        // everything at zero: instant confirms and faults
        c = '0;
        run_phase(c, 80, 5, 1'b1);

        // everything at its top: long runs needed to confirm anything
        c = '1;
        run_phase(c, 300, 400, 1'b0);

        // random small counts and random thresholds
        for (int k = 0; k < 4; k++)
        begin
            c.confirm_high_count   = 8'($urandom_range(0, 6));
            c.confirm_low_count    = 8'($urandom_range(0, 6));
            c.fault_confirm_count  = 8'($urandom_range(0, 24));
            c.rehab_count          = 8'($urandom_range(0, 8));
            c.pedal_threshold_high = 16'($urandom);
            c.pedal_threshold_low  = 16'($urandom);
            run_phase(c, 90, 12, k[0]);
        end

        drain();
        if (tracker.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/ksq_pkg.sv
src/ksq_cfg_regs.sv
src/ksq_fsm.sv
src/kickdown_switch_qualifier_unit.sv
bench/tb_kickdown_switch_qualifier_unit.sv
